// ===== hw/rtl/quad_geometric_weights_defines.svh =====
// quad_geometric_weights_defines.svh
// Assertion macros used by the checker file qgw_checker.sv.
`ifndef QUAD_GEOMETRIC_WEIGHTS_DEFINES_SVH
`define QUAD_GEOMETRIC_WEIGHTS_DEFINES_SVH

// Clocked assertion, off while reset is high.
`define QGW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define QGW_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/qgw_pkg.sv =====
// ----------------------------------------------------------------------------
// qgw_pkg
// Types, constants and rounding helper for the quad geometric weights block.
// ----------------------------------------------------------------------------
package qgw_pkg;

   localparam int CORNER_CNT = 4;
   localparam int CSR_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int LANE_CNT   = 3;
   localparam int DIV_STEPS  = 32;
   localparam int DIV_LAT    = DIV_STEPS + 2;
   localparam int NUM_W      = 95;
   localparam int DEN_W      = 76;

   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_X0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_X1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_X2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_X3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_Y0 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_Y1 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_Y2 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_Y3 = 3'd7;

   typedef struct packed {
      logic signed [15:0] ref_xsi;
      logic signed [15:0] ref_eta;
      logic [15:0]        weight_xsi;
      logic [15:0]        weight_eta;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic signed [31:0] w_xi_xi;
      logic signed [31:0] w_xi_eta;
      logic signed [31:0] w_eta_eta;
      logic signed [31:0] jacobian_value;
      logic               degenerate;
      logic               last_out;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] dxdxsi;
      logic signed [31:0] dxdeta;
      logic signed [31:0] dydxsi;
      logic signed [31:0] dydeta;
      logic [31:0]        weight;
      logic               last;
   } deriv_type;

   typedef struct packed {
      logic signed [31:0] jacobian_value;
      logic               degenerate;
      logic               last;
   } side_type;

   typedef struct packed {
      logic [LANE_CNT-1:0][NUM_W-1:0] num;
      logic [LANE_CNT-1:0]            neg;
      logic [DEN_W-1:0]               den;
      side_type                       side;
   } metric_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic             neg;
      logic             zero;
   } div_in_type;

   // Round a 2^-32 value to Q16.16, half away from zero, symmetric saturation.
   function automatic logic signed [31:0] round_q16(input logic signed [63:0] v);
      logic [63:0] mag;
      logic [48:0] rnd;
      mag = v[63] ? (64'd0 - 64'(v)) : 64'(v);
      rnd = {1'b0, mag[63:16]} + {48'd0, mag[15]};
      if (rnd > 49'h0_7FFF_FFFF) begin
         rnd = 49'h0_7FFF_FFFF;
      end
      round_q16 = v[63] ? (32'd0 - rnd[31:0]) : rnd[31:0];
   endfunction

endpackage

// ===== hw/rtl/qgw_deriv.sv =====
// ----------------------------------------------------------------------------
// qgw_deriv
// Three-stage pipeline forming the four bilinear map derivatives.
// ----------------------------------------------------------------------------
module qgw_deriv import qgw_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic [CORNER_CNT-1:0][CSR_W-1:0] corner_x,
   input  logic [CORNER_CNT-1:0][CSR_W-1:0] corner_y,
   input  logic                             in_valid,
   input  req_type                          in_data,
   output logic                             out_valid,
   output deriv_type                        out_data
);

   function automatic logic signed [32:0] cdiff(input logic [31:0] a, input logic [31:0] b);
      cdiff = 33'(signed'(a)) - 33'(signed'(b));
   endfunction

   logic signed [32:0] dif_in [8];
   logic signed [17:0] tm_xsi, tp_xsi, tm_eta, tp_eta;
   logic signed [50:0] prod_in [8];

   logic signed [50:0] prod_ff [8];
   logic [31:0]        w1_ff;
   logic               last1_ff, v1_ff;
   logic signed [51:0] sum_ff [4];
   logic [31:0]        w2_ff;
   logic               last2_ff, v2_ff;
   deriv_type          out_ff;
   logic               v3_ff;

   always_comb begin
      tm_eta = 18'sd16384 - 18'(in_data.ref_eta);
      tp_eta = 18'sd16384 + 18'(in_data.ref_eta);
      tm_xsi = 18'sd16384 - 18'(in_data.ref_xsi);
      tp_xsi = 18'sd16384 + 18'(in_data.ref_xsi);
      dif_in[0] = cdiff(corner_x[1], corner_x[0]);
      dif_in[1] = cdiff(corner_x[3], corner_x[2]);
      dif_in[2] = cdiff(corner_x[2], corner_x[0]);
      dif_in[3] = cdiff(corner_x[3], corner_x[1]);
      dif_in[4] = cdiff(corner_y[1], corner_y[0]);
      dif_in[5] = cdiff(corner_y[3], corner_y[2]);
      dif_in[6] = cdiff(corner_y[2], corner_y[0]);
      dif_in[7] = cdiff(corner_y[3], corner_y[1]);
      prod_in[0] = 51'(dif_in[0]) * 51'(tm_eta);
      prod_in[1] = 51'(dif_in[1]) * 51'(tp_eta);
      prod_in[2] = 51'(dif_in[2]) * 51'(tm_xsi);
      prod_in[3] = 51'(dif_in[3]) * 51'(tp_xsi);
      prod_in[4] = 51'(dif_in[4]) * 51'(tm_eta);
      prod_in[5] = 51'(dif_in[5]) * 51'(tp_eta);
      prod_in[6] = 51'(dif_in[6]) * 51'(tm_xsi);
      prod_in[7] = 51'(dif_in[7]) * 51'(tp_xsi);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 8; i++) begin
            prod_ff[i] <= prod_in[i];
         end
         w1_ff    <= 32'(in_data.weight_xsi) * 32'(in_data.weight_eta);
         last1_ff <= in_data.last_point;
         for (int i = 0; i < 4; i++) begin
            sum_ff[i] <= 52'(prod_ff[2*i]) + 52'(prod_ff[2*i+1]);
         end
         w2_ff    <= w1_ff;
         last2_ff <= last1_ff;
         out_ff.dxdxsi <= round_q16(64'(sum_ff[0]));
         out_ff.dxdeta <= round_q16(64'(sum_ff[1]));
         out_ff.dydxsi <= round_q16(64'(sum_ff[2]));
         out_ff.dydeta <= round_q16(64'(sum_ff[3]));
         out_ff.weight <= w2_ff;
         out_ff.last   <= last2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = out_ff;

endmodule

// ===== hw/rtl/qgw_metric.sv =====
// ----------------------------------------------------------------------------
// qgw_metric
// Five-stage pipeline: Jacobian, metric numerators, divider operands.
// ----------------------------------------------------------------------------
module qgw_metric import qgw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       in_valid,
   input  deriv_type  in_data,
   output logic       out_valid,
   output metric_type out_data
);

   logic signed [63:0] p_ff [8];
   logic [31:0]        w1_ff, w2_ff, w3_ff;
   logic               last1_ff, last2_ff, last3_ff, last4_ff;
   logic signed [63:0] jac2_ff, jac3_ff;
   logic signed [63:0] num2_ff [LANE_CNT];
   logic [62:0]        mag3_ff [LANE_CNT];
   logic [LANE_CNT-1:0] neg3_ff, neg4_ff;
   logic [DEN_W-1:0]   den3_ff, den4_ff;
   logic               degen3_ff, degen4_ff;
   logic [63:0]        lo4_ff [LANE_CNT];
   logic [62:0]        hi4_ff [LANE_CNT];
   logic signed [31:0] jv4_ff;
   metric_type         out_ff;
   logic [4:0]         v_ff;
   logic [63:0]        jmag_in;

   assign jmag_in = jac2_ff[63] ? (64'd0 - 64'(jac2_ff)) : 64'(jac2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0]  <= 64'(in_data.dxdxsi) * 64'(in_data.dydeta);
         p_ff[1]  <= 64'(in_data.dxdeta) * 64'(in_data.dydxsi);
         p_ff[2]  <= 64'(in_data.dydeta) * 64'(in_data.dydeta);
         p_ff[3]  <= 64'(in_data.dxdeta) * 64'(in_data.dxdeta);
         p_ff[4]  <= 64'(in_data.dydeta) * 64'(in_data.dydxsi);
         p_ff[5]  <= 64'(in_data.dxdeta) * 64'(in_data.dxdxsi);
         p_ff[6]  <= 64'(in_data.dydxsi) * 64'(in_data.dydxsi);
         p_ff[7]  <= 64'(in_data.dxdxsi) * 64'(in_data.dxdxsi);
         w1_ff    <= in_data.weight;
         last1_ff <= in_data.last;

         jac2_ff    <= p_ff[0] - p_ff[1];
         num2_ff[0] <= p_ff[2] + p_ff[3];
         num2_ff[1] <= 64'sd0 - (p_ff[4] + p_ff[5]);
         num2_ff[2] <= p_ff[6] + p_ff[7];
         w2_ff      <= w1_ff;
         last2_ff   <= last1_ff;

         for (int i = 0; i < LANE_CNT; i++) begin
            mag3_ff[i] <= num2_ff[i][63] ? 63'(64'd0 - 64'(num2_ff[i])) : num2_ff[i][62:0];
            neg3_ff[i] <= num2_ff[i][63] ^ jac2_ff[63];
         end
         den3_ff   <= DEN_W'({jmag_in[62:0], 12'd0});
         degen3_ff <= (jac2_ff == 64'sd0);
         jac3_ff   <= jac2_ff;
         w3_ff     <= w2_ff;
         last3_ff  <= last2_ff;

         // split the 63x32 product into two partial products
         for (int i = 0; i < LANE_CNT; i++) begin
            lo4_ff[i] <= 64'(mag3_ff[i][31:0]) * 64'(w3_ff);
            hi4_ff[i] <= 63'(mag3_ff[i][62:32]) * 63'(w3_ff);
         end
         jv4_ff    <= round_q16(jac3_ff);
         neg4_ff   <= neg3_ff;
         den4_ff   <= den3_ff;
         degen4_ff <= degen3_ff;
         last4_ff  <= last3_ff;

         for (int i = 0; i < LANE_CNT; i++) begin
            out_ff.num[i] <= NUM_W'(lo4_ff[i]) + NUM_W'({hi4_ff[i], 32'd0});
         end
         out_ff.neg                 <= neg4_ff;
         out_ff.den                 <= den4_ff;
         out_ff.side.jacobian_value <= jv4_ff;
         out_ff.side.degenerate     <= degen4_ff;
         out_ff.side.last           <= last4_ff;
      end
   end

   assign out_valid = v_ff[4];
   assign out_data  = out_ff;

endmodule

// ===== hw/rtl/qgw_div.sv =====
// ----------------------------------------------------------------------------
// qgw_div
// Pipelined restoring divider, one quotient bit per stage, with rounding
// to nearest and signed saturation in the last stage.
// ----------------------------------------------------------------------------
module qgw_div import qgw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  div_in_type         in_data,
   output logic               out_valid,
   output logic signed [31:0] out_quot
);

   logic                 valid_ff [DIV_STEPS+1];
   logic [DEN_W-1:0]     rem_ff   [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] quo_ff   [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] low_ff   [DIV_STEPS+1];
   logic [DEN_W-1:0]     den_ff   [DIV_STEPS+1];
   logic                 ovf_ff   [DIV_STEPS+1];
   logic                 neg_ff   [DIV_STEPS+1];
   logic                 zero_ff  [DIV_STEPS+1];

   logic [DEN_W-1:0]     rem_in [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] quo_in [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] low_in [DIV_STEPS+1];
   logic                 ovf_in;

   logic                 out_valid_ff;
   logic signed [31:0]   out_ff, res_in;

   logic [DEN_W:0]       trial;
   logic                 ge;
   logic                 rnd;
   logic [DIV_STEPS:0]   qr, lim, mq;

   always_comb begin
      trial = '0;
      ge    = 1'b0;
      rem_in[0] = DEN_W'(in_data.num[NUM_W-1:DIV_STEPS]);
      quo_in[0] = '0;
      low_in[0] = in_data.num[DIV_STEPS-1:0];
      ovf_in    = DEN_W'(in_data.num[NUM_W-1:DIV_STEPS]) >= in_data.den;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         trial = {rem_ff[k-1], low_ff[k-1][DIV_STEPS-1]};
         ge    = trial >= {1'b0, den_ff[k-1]};
         rem_in[k] = ge ? DEN_W'(trial - {1'b0, den_ff[k-1]}) : trial[DEN_W-1:0];
         quo_in[k] = {quo_ff[k-1][DIV_STEPS-2:0], ge};
         low_in[k] = {low_ff[k-1][DIV_STEPS-2:0], 1'b0};
      end
   end

   // round to nearest, then clamp to the signed range
   always_comb begin
      rnd = {rem_ff[DIV_STEPS], 1'b0} >= {1'b0, den_ff[DIV_STEPS]};
      qr  = {1'b0, quo_ff[DIV_STEPS]} + (DIV_STEPS+1)'(rnd);
      lim = neg_ff[DIV_STEPS] ? {2'b01, {(DIV_STEPS-1){1'b0}}}
                              : {2'b00, {(DIV_STEPS-1){1'b1}}};
      mq  = (ovf_ff[DIV_STEPS] || (qr > lim)) ? lim : qr;
      if (zero_ff[DIV_STEPS]) begin
         res_in = '0;
      end else if (neg_ff[DIV_STEPS]) begin
         res_in = 32'd0 - mq[31:0];
      end else begin
         res_in = mq[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            valid_ff[k] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         out_valid_ff <= valid_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= rem_in[0];
         quo_ff[0]  <= quo_in[0];
         low_ff[0]  <= low_in[0];
         den_ff[0]  <= in_data.den;
         ovf_ff[0]  <= ovf_in;
         neg_ff[0]  <= in_data.neg;
         zero_ff[0] <= in_data.zero;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            rem_ff[k]  <= rem_in[k];
            quo_ff[k]  <= quo_in[k];
            low_ff[k]  <= low_in[k];
            den_ff[k]  <= den_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
         end
         out_ff <= res_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_quot  = out_ff;

endmodule

// ===== hw/rtl/quad_geometric_weights.sv =====
// A request passes 3 derivative, 5 metric and 34 divider stages on its way to
// its response. Throughput: one point per cycle while no response is stalled; the rate is
// set by the bit-per-stage dividers, which take a new operand every cycle.
// A stalled response freezes the whole pipeline, empty stages included.
// Reset (synchronous): clears all valid bits and sets the corners to zero.
// ----------------------------------------------------------------------------
// quad_geometric_weights
// Bilinear quad Jacobian and weighted inverse-metric terms per grid point.
// ----------------------------------------------------------------------------
module quad_geometric_weights import qgw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic [CORNER_CNT-1:0][CSR_W-1:0] corner_x_ff, corner_y_ff;
   logic                 en;
   logic                 drv_valid, met_valid;
   deriv_type            drv_data;
   metric_type           met_data;
   div_in_type           div_in [LANE_CNT];
   logic                 div_valid;
   logic signed [31:0]   quot [LANE_CNT];
   side_type             side_ff [DIV_LAT];

   // advance unless a response is held
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_x_ff <= '0;
         corner_y_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CORNER_X0: corner_x_ff[0] <= csr_wdata;
            CSR_CORNER_X1: corner_x_ff[1] <= csr_wdata;
            CSR_CORNER_X2: corner_x_ff[2] <= csr_wdata;
            CSR_CORNER_X3: corner_x_ff[3] <= csr_wdata;
            CSR_CORNER_Y0: corner_y_ff[0] <= csr_wdata;
            CSR_CORNER_Y1: corner_y_ff[1] <= csr_wdata;
            CSR_CORNER_Y2: corner_y_ff[2] <= csr_wdata;
            CSR_CORNER_Y3: corner_y_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   qgw_deriv u_deriv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .corner_x  (corner_x_ff),
      .corner_y  (corner_y_ff),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (drv_valid),
      .out_data  (drv_data)
   );

   qgw_metric u_metric (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (drv_valid),
      .in_data   (drv_data),
      .out_valid (met_valid),
      .out_data  (met_data)
   );

   always_comb begin
      for (int i = 0; i < LANE_CNT; i++) begin
         div_in[i].num  = met_data.num[i];
         div_in[i].den  = met_data.den;
         div_in[i].neg  = met_data.neg[i];
         div_in[i].zero = met_data.side.degenerate;
      end
   end

   qgw_div u_div0 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (met_valid),
      .in_data   (div_in[0]),
      .out_valid (div_valid),
      .out_quot  (quot[0])
   );

   qgw_div u_div1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (met_valid),
      .in_data   (div_in[1]),
      .out_valid (),
      .out_quot  (quot[1])
   );

   qgw_div u_div2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (met_valid),
      .in_data   (div_in[2]),
      .out_valid (),
      .out_quot  (quot[2])
   );

   // carry Jacobian, flag and mark alongside the dividers
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= met_data.side;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign rsp_valid               = div_valid;
   assign rsp_data.w_xi_xi        = quot[0];
   assign rsp_data.w_xi_eta       = quot[1];
   assign rsp_data.w_eta_eta      = quot[2];
   assign rsp_data.jacobian_value = side_ff[DIV_LAT-1].jacobian_value;
   assign rsp_data.degenerate     = side_ff[DIV_LAT-1].degenerate;
   assign rsp_data.last_out       = side_ff[DIV_LAT-1].last;

endmodule

// ===== hw/rtl/qgw_checker.sv =====
// ----------------------------------------------------------------------------
// qgw_checker
// Port-level checks for quad_geometric_weights, attached by bind.
// ----------------------------------------------------------------------------
`include "quad_geometric_weights_defines.svh"

module qgw_checker import qgw_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input req_type              req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rsp_type              rsp_data,
   input logic                 csr_write,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [CSR_W-1:0]     csr_wdata
);

   `QGW_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "response valid right after reset")

   `QGW_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled response changed")

   `QGW_ASSERT(a_stall_cause, req_stall |-> rsp_valid && rsp_stall, "request stalled without a held response")

   `QGW_ASSERT(a_degen_zero, rsp_valid && rsp_data.degenerate |-> rsp_data.w_xi_xi == 32'sd0 && rsp_data.w_xi_eta == 32'sd0 && rsp_data.w_eta_eta == 32'sd0 && rsp_data.jacobian_value == 32'sd0, "degenerate result carries nonzero terms")

   `QGW_ASSERT(a_jac_sym, rsp_valid |-> rsp_data.jacobian_value != 32'sh8000_0000, "Jacobian saturated asymmetrically")

endmodule

bind quad_geometric_weights qgw_checker u_qgw_checker (.*);
